/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, clocked on clk_i and held off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define BSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen out of reset
`define BSS_NEVER(lbl, cond, msg) \
  `BSS_ASSERT(lbl, !(cond), msg)

`endif

/* src/bss_pkg.sv */
// ----------------------------------------------------------------------------
// bss_pkg
// transaction types and action codes of the sorted table search block
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam int unsigned IDX_W = 10;
  localparam int unsigned VAL_W = 32;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] entry_value;
    logic signed [VAL_W-1:0] search_key;
    logic [IDX_W-1:0]        low_bound;
    logic [IDX_W-1:0]        high_bound;
  } bss_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } bss_res_t;

  localparam bss_res_t RES_NOT_FOUND = '{found: 1'b0, match_index: '0};

endpackage

`default_nettype wire

/* src/bss_table.sv */
// ----------------------------------------------------------------------------
// bss_table
// entry store: two copies of the table, three synchronous read ports in all
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bss_table
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    wr_en_i,
  input  wire logic [AW-1:0]           wr_addr_i,
  input  wire logic signed [VAL_W-1:0] wr_data_i,
  input  wire logic                    rd_en_i,
  input  wire logic [AW-1:0]           rd_mid_i,
  input  wire logic [AW-1:0]           rd_lo_i,
  input  wire logic [AW-1:0]           rd_hi_i,
  output logic signed [VAL_W-1:0]      mid_data_o,
  output logic signed [VAL_W-1:0]      lo_data_o,
  output logic signed [VAL_W-1:0]      hi_data_o
);

  // copy a serves the mid and low probes, copy b the high probe
  logic signed [VAL_W-1:0] mem_a [DEPTH];
  logic signed [VAL_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_a[wr_addr_i] <= wr_data_i;
      mem_b[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      mid_data_o <= mem_a[rd_mid_i];
      lo_data_o  <= mem_a[rd_lo_i];
      hi_data_o  <= mem_b[rd_hi_i];
    end
  end

  // loads and probes are never issued in the same cycle
  `BSS_NEVER(a_no_rw_overlap, wr_en_i && rd_en_i, "table write and read in one cycle")

endmodule

`default_nettype wire

/* src/bss_ctrl.sv */
// ----------------------------------------------------------------------------
// bss_ctrl
// search sequencer: range registers, probe compare and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bss_ctrl
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire bss_req_t                req_i,
  output logic                         done_o,
  output bss_res_t                     res_o,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output logic signed [VAL_W-1:0]      wr_data_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_mid_o,
  output logic [AW-1:0]                rd_lo_o,
  output logic [AW-1:0]                rd_hi_o,
  input  wire logic signed [VAL_W-1:0] mid_data_i,
  input  wire logic signed [VAL_W-1:0] lo_data_i,
  input  wire logic signed [VAL_W-1:0] hi_data_i
);

  localparam logic [0:0]  S_IDLE  = 1'b0;
  localparam logic [0:0]  S_CMP   = 1'b1;
  localparam logic [31:0] DEPTH_W = 32'(DEPTH);

  logic [0:0]              state_q, state_d;
  logic [AW-1:0]           lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic signed [VAL_W-1:0] key_q, key_d;
  logic                    done_q, done_d;
  bss_res_t                res_q, res_d;

  logic [31:0]   lo_ext, hi_ext, idx_ext, lo_sat, hi_sat;
  logic [AW-1:0] lo_in, hi_in;
  logic          idx_ok;
  logic [AW:0]   sum;
  logic          eq_mid, eq_lo, eq_hi, go_down, empty;

  // saturate the bounds to the last entry
  assign lo_ext  = 32'(req_i.low_bound);
  assign hi_ext  = 32'(req_i.high_bound);
  assign idx_ext = 32'(req_i.entry_index);
  assign lo_sat  = (lo_ext >= DEPTH_W) ? DEPTH_W - 32'd1 : lo_ext;
  assign hi_sat  = (hi_ext >= DEPTH_W) ? DEPTH_W - 32'd1 : hi_ext;
  assign lo_in   = lo_sat[AW-1:0];
  assign hi_in   = hi_sat[AW-1:0];
  assign idx_ok  = idx_ext < DEPTH_W;

  assign eq_mid  = mid_data_i == key_q;
  assign eq_lo   = lo_data_i == key_q;
  assign eq_hi   = hi_data_i == key_q;
  assign go_down = key_q < mid_data_i;
  // mid lies in [lo, hi], so the next half is empty exactly at the edge
  assign empty   = go_down ? (mid_q == lo_q) : (mid_q == hi_q);

  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    key_d   = key_q;
    done_d  = 1'b0;
    res_d   = res_q;
    rd_en_o = 1'b0;
    wr_en_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (req_i.action == ACT_LOAD) begin
            wr_en_o = idx_ok;
          end else begin
            key_d = req_i.search_key;
            lo_d  = lo_in;
            hi_d  = hi_in;
            if (lo_in > hi_in) begin
              done_d = 1'b1;
              res_d  = RES_NOT_FOUND;
            end else begin
              rd_en_o = 1'b1;
              state_d = S_CMP;
            end
          end
        end
      end
      S_CMP: begin
        if (eq_mid || eq_lo || eq_hi) begin
          done_d      = 1'b1;
          res_d.found = 1'b1;
          if (eq_mid) begin
            res_d.match_index = IDX_W'(mid_q);
          end else if (eq_lo) begin
            res_d.match_index = IDX_W'(lo_q);
          end else begin
            res_d.match_index = IDX_W'(hi_q);
          end
          state_d = S_IDLE;
        end else if (empty) begin
          done_d  = 1'b1;
          res_d   = RES_NOT_FOUND;
          state_d = S_IDLE;
        end else begin
          // next probe is issued straight from the narrowed range
          if (go_down) begin
            hi_d = mid_q - AW'(1);
          end else begin
            lo_d = mid_q + AW'(1);
          end
          rd_en_o = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign sum   = {1'b0, lo_d} + {1'b0, hi_d};
  assign mid_d = sum[AW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    key_q <= key_d;
    res_q <= res_d;
    if (rd_en_o) begin
      mid_q <= mid_d;
    end
  end

  assign busy      = state_q == S_CMP;
  assign done_o    = done_q;
  assign res_o     = res_q;
  assign wr_addr_o = idx_ext[AW-1:0];
  assign wr_data_o = req_i.entry_value;
  assign rd_mid_o  = mid_d;
  assign rd_lo_o   = lo_d;
  assign rd_hi_o   = hi_d;

  `BSS_ASSERT(a_done_cause, done_o |-> ($past(state_q == S_CMP) || $past(start && req_i.action == ACT_SEARCH)), "result without a search")
  `BSS_ASSERT(a_mid_in_range, state_q == S_CMP |-> (lo_q <= mid_q && mid_q <= hi_q), "probe index outside range")
  `BSS_ASSERT(a_range_shrinks, (state_q == S_CMP && $past(state_q == S_CMP)) |-> ((hi_q - lo_q) < $past(hi_q - lo_q)), "search range did not shrink")
  `BSS_ASSERT(a_miss_index_zero, (done_o && !res_o.found) |-> (res_o.match_index == '0), "miss with non-zero index")

endmodule

`default_nettype wire

/* src/binary_search_sorted_table.sv */
// ----------------------------------------------------------------------------
// binary_search_sorted_table
// sorted table of signed entries with binary search lookup
// ----------------------------------------------------------------------------
// usage
//   one command channel: a transaction is taken at a clock edge with start
//   high and busy low. action selects a load of one table entry or a search.
//   a load writes entry_index in that cycle and gives no result; loads may
//   follow each other every cycle. a load past the table is dropped.
//   a search saturates its bounds to the last entry and probes mid, low and
//   high of the range each cycle, one registered read of the entry memory
//   per probe (two table copies give the three read ports).
//   the result strobe done_o is high for one cycle; it is registered from the
//   compare of the last probe, and the number of probes is at most
//   clog2(TABLE_DEPTH)+1, so 11 at the default depth; an empty range
//   answers in the cycle after it is taken. busy is high while the probes
//   run and drops in the strobe cycle, so the next command is taken at its
//   end at the earliest; a search on an empty range does not raise busy.
//   the receiver cannot hold results off; res_o is valid only with done_o.
//   reset clears the sequencer and the strobe; table contents are undefined
//   until loaded and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_search_sorted_table
  import bss_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire bss_req_t req_i,
  output logic          done_o,
  output bss_res_t      res_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_mid, rd_lo, rd_hi;
  logic signed [VAL_W-1:0] wr_data, mid_data, lo_data, hi_data;

  bss_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .res_o      (res_o),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_mid_o   (rd_mid),
    .rd_lo_o    (rd_lo),
    .rd_hi_o    (rd_hi),
    .mid_data_i (mid_data),
    .lo_data_i  (lo_data),
    .hi_data_i  (hi_data)
  );

  bss_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd_en_i    (rd_en),
    .rd_mid_i   (rd_mid),
    .rd_lo_i    (rd_lo),
    .rd_hi_i    (rd_hi),
    .mid_data_o (mid_data),
    .lo_data_o  (lo_data),
    .hi_data_o  (hi_data)
  );

endmodule

`default_nettype wire

/* tb/tb_binary_search_sorted_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_search_sorted_table
// self-checking bench for the sorted table search block
// ----------------------------------------------------------------------------
// a short stimulus table covers empty ranges, the value and index extremes,
// single-entry ranges, misses and an out-of-order entry. the random part
// then loads runs of entries, mostly ascending, and searches ranges that
// are fully loaded or, now and then, empty. results are checked against the
// stated value, else a mirror of the table and a copy of the probe sequence.
// ----------------------------------------------------------------------------

module tb_binary_search_sorted_table;
  import bss_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int ITEM_TARGET = 1400;
  localparam int CYCLE_LIMIT = 300000;
  localparam int TAIL_CYCLES = 20;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    bss_req_t req;
    bit       typed;
    bss_res_t want;
  } stim_row_t;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     start  = 1'b0;
  bss_req_t req    = '0;
  logic     busy;
  logic     done_o;
  bss_res_t res_o;

  logic signed [VAL_W-1:0] entry_copy   [DEPTH];
  bit                      entry_loaded [DEPTH];
  bss_res_t                pending_lookups [$];

  int sender_idle_pct = 0;
  int items_sent      = 0;
  int fail_count      = 0;
  int cycle_count     = 0;

  binary_search_sorted_table #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    fail_count++;
  endtask

  // probe sequence: mid, then low, then high, then halve the range
  function automatic bss_res_t lookup_entry(input bss_req_t r);
    int       lo;
    int       hi;
    int       mid;
    bss_res_t res;
    lo = int'(r.low_bound);
    hi = int'(r.high_bound);
    if (lo >= DEPTH) lo = DEPTH - 1;
    if (hi >= DEPTH) hi = DEPTH - 1;
    res = RES_NOT_FOUND;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      res.found = 1'b1;
      if (r.search_key == entry_copy[mid]) begin
        res.match_index = IDX_W'(mid);
        return res;
      end
      if (r.search_key == entry_copy[lo]) begin
        res.match_index = IDX_W'(lo);
        return res;
      end
      if (r.search_key == entry_copy[hi]) begin
        res.match_index = IDX_W'(hi);
        return res;
      end
      if (r.search_key < entry_copy[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return RES_NOT_FOUND;
  endfunction

  function automatic stim_row_t load_row(input int idx, input logic signed [VAL_W-1:0] val);
    stim_row_t row;
    row.req             = '0;
    row.req.action      = ACT_LOAD;
    row.req.entry_index = IDX_W'(idx);
    row.req.entry_value = val;
    row.typed           = 1'b0;
    row.want            = RES_NOT_FOUND;
    return row;
  endfunction

  function automatic stim_row_t search_row(input logic signed [VAL_W-1:0] key, input int lo,
                                           input int hi, input bit typed, input bit hit,
                                           input int where);
    stim_row_t row;
    row.req                  = '0;
    row.req.action           = ACT_SEARCH;
    row.req.search_key       = key;
    row.req.low_bound        = IDX_W'(lo);
    row.req.high_bound       = IDX_W'(hi);
    row.typed                = typed;
    row.want.found           = hit;
    row.want.match_index     = IDX_W'(where);
    return row;
  endfunction

  // one transaction on the command channel, with random idle cycles ahead of it
  task automatic send_item(input bss_req_t r, input bit typed, input bss_res_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    items_sent++;
    if (r.action == ACT_LOAD) begin
      if (int'(r.entry_index) < DEPTH) begin
        entry_copy[r.entry_index]   = r.entry_value;
        entry_loaded[r.entry_index] = 1'b1;
      end
    end else begin
      pending_lookups.push_back(typed ? want : lookup_entry(r));
    end
  endtask

  // always waits at least one edge, so start is never driven twice in a step
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_lookups.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    bss_res_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("search result with no search outstanding");
      end else begin
        want = pending_lookups.pop_front();
        if (res_o.found !== want.found)
          report_mismatch($sformatf("found: got %b, expected %b", res_o.found, want.found));
        if (res_o.match_index !== want.match_index)
          report_mismatch($sformatf("match_index: got %0d, expected %0d",
                                    res_o.match_index, want.match_index));
      end
    end
  end

  initial begin : stimulus
    stim_row_t               directed_rows [$];
    bss_req_t                r;
    logic signed [VAL_W-1:0] v;
    longint                  acc;
    int                      phase;
    int                      region_base;
    int                      region_len;
    int                      style;
    int                      run_lo;
    int                      run_hi;
    int                      lo;
    int                      hi;
    int                      a;
    int                      b;
    int                      pick;
    int                      sel;
    int                      n_search;

    directed_rows = {
      // empty ranges straight after reset, nothing is read
      search_row(0, 5, 4, 1'b1, 1'b0, 0),
      search_row(VAL_MAX, 1023, 0, 1'b1, 1'b0, 0),
      load_row(0, VAL_MIN),
      load_row(1, -5),
      load_row(2, 0),
      load_row(3, 7),
      load_row(4, VAL_MAX),
      search_row(VAL_MIN, 0, 4, 1'b1, 1'b1, 0),
      search_row(VAL_MAX, 0, 4, 1'b1, 1'b1, 4),
      search_row(0, 0, 4, 1'b1, 1'b1, 2),
      search_row(-5, 0, 4, 1'b0, 1'b0, 0),
      search_row(7, 0, 4, 1'b0, 1'b0, 0),
      search_row(6, 0, 4, 1'b0, 1'b0, 0),
      search_row(7, 3, 3, 1'b0, 1'b0, 0),
      search_row(8, 3, 3, 1'b0, 1'b0, 0),
      load_row(1023, VAL_MAX),
      load_row(1022, 100),
      load_row(1021, -100),
      search_row(VAL_MAX, 1021, 1023, 1'b1, 1'b1, 1023),
      search_row(-100, 1021, 1023, 1'b0, 1'b0, 0),
      search_row(101, 1021, 1023, 1'b0, 1'b0, 0),
      // out-of-order entry at the end of the low run
      load_row(5, VAL_MIN),
      search_row(VAL_MIN, 1, 5, 1'b0, 1'b0, 0),
      search_row(1, 0, 5, 1'b0, 1'b0, 0),
      search_row(0, 4, 4, 1'b0, 1'b0, 0)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 53;
        default: sender_idle_pct = 31;
      endcase
      phase++;

      // mostly short runs, now and then a long one
      region_len  = ($urandom_range(9) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 32);
      region_base = $urandom_range(0, DEPTH - region_len);
      sel = $urandom_range(9);
      if (sel == 0) region_base = 0;
      else if (sel == 1) region_base = DEPTH - region_len;

      // globally monotone values keep merged runs sorted; the rest are local
      style = $urandom_range(9);
      acc   = ($urandom_range(3) == 0) ? longint'(VAL_MIN) : longint'($signed($urandom()));
      for (int i = 0; i < region_len; i++) begin
        if (style < 7) begin
          v = 32'(longint'(region_base + i) * 64'sd4194304 - 64'sd2147483648
                  + longint'($urandom_range(0, 4194303)));
        end else begin
          acc = acc + longint'($urandom_range(0, 1000));
          if (acc > longint'(VAL_MAX)) acc = longint'(VAL_MAX);
          v = 32'(acc);
        end
        r             = '0;
        r.action      = ACT_LOAD;
        r.entry_index = IDX_W'(region_base + i);
        r.entry_value = v;
        r.search_key  = 32'($urandom());
        r.low_bound   = IDX_W'($urandom());
        r.high_bound  = IDX_W'($urandom());
        send_item(r, 1'b0, RES_NOT_FOUND);
      end

      // stray write, may break the order of a run
      if ($urandom_range(3) == 0) begin
        r             = '0;
        r.action      = ACT_LOAD;
        r.entry_index = IDX_W'($urandom());
        r.entry_value = 32'($urandom());
        send_item(r, 1'b0, RES_NOT_FOUND);
      end

      run_lo = region_base;
      run_hi = region_base + region_len - 1;
      while (run_lo > 0 && entry_loaded[run_lo - 1]) run_lo--;
      while (run_hi < DEPTH - 1 && entry_loaded[run_hi + 1]) run_hi++;

      n_search = $urandom_range(3, 12);
      for (int s = 0; s < n_search; s++) begin
        r             = '0;
        r.action      = ACT_SEARCH;
        r.entry_index = IDX_W'($urandom());
        r.entry_value = 32'($urandom());
        if ($urandom_range(9) == 0) begin
          lo = $urandom_range(1, DEPTH - 1);
          hi = $urandom_range(0, lo - 1);
        end else if ($urandom_range(1) == 0) begin
          lo = run_lo;
          hi = run_hi;
        end else begin
          a  = $urandom_range(run_lo, run_hi);
          b  = $urandom_range(run_lo, run_hi);
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
        r.low_bound  = IDX_W'(lo);
        r.high_bound = IDX_W'(hi);
        sel = $urandom_range(9);
        if (lo > hi || sel == 8) begin
          r.search_key = 32'($urandom());
        end else begin
          pick = $urandom_range(lo, hi);
          if (sel < 6) r.search_key = entry_copy[pick];
          else if (sel == 9) r.search_key = $urandom_range(1) ? VAL_MAX : VAL_MIN;
          else r.search_key = 32'(entry_copy[pick] + 32'sd1);
        end
        send_item(r, 1'b0, RES_NOT_FOUND);
      end

      if ($urandom_range(7) == 0) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
